// File: sv/nfrag_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the notification payload fragmenter
package nfrag_pkg;

    localparam int ByteW   = 8;
    localparam int LenW    = 12;
    localparam int MtuW    = 10;
    localparam int ChunkW  = 9;
    localparam int NumW    = 13;
    localparam int IdxW    = 8;
    localparam int BifW    = 10;
    localparam int HdrCntW = 2;

    localparam int DivSteps = NumW;
    localparam int DivCntW  = 4;

    localparam int MtuMin         = 23;
    localparam int MtuMax         = 517;
    localparam int PassOverhead   = 3;
    localparam int SplitOverhead  = 7;
    localparam int MtuReset       = 23;
    localparam int MaxMessageBytesDef = 4080;

    localparam logic [ByteW-1:0] HashByte = 8'h23;

    // configuration register indexes
    localparam logic CfgMtu    = 1'b0;
    localparam logic CfgNotify = 1'b1;

    // header byte positions
    localparam logic [HdrCntW-1:0] HdrHash0 = 2'd0;
    localparam logic [HdrCntW-1:0] HdrHash1 = 2'd1;
    localparam logic [HdrCntW-1:0] HdrTotal = 2'd2;
    localparam logic [HdrCntW-1:0] HdrIndex = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HDR,
        ST_DATA
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_store;
        logic hdr_emit;
        logic data_step;
    } t_cmd;

    typedef struct packed {
        logic first_split;
        logic hdr_needed;
        logic div_done;
        logic hdr_last;
        logic slot_free;
        logic notify;
    } t_status;

endpackage

// File: sv/nfrag_ctrl.sv
`timescale 1ns / 1ps
// sequencing state machine of the notification payload fragmenter
module nfrag_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  nfrag_pkg::t_status i_status,
    output nfrag_pkg::t_cmd   o_cmd,
    output logic              o_in_stall
);
    import nfrag_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    priority if (i_status.first_split) begin
                        n_state = ST_DIV;
                    end else if (i_status.hdr_needed && i_status.notify) begin
                        n_state = ST_HDR;
                    end else begin
                        n_state = ST_DATA;
                    end
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = i_status.notify ? ST_HDR : ST_DATA;
                end
            end
            ST_HDR: begin
                if (i_status.slot_free && i_status.hdr_last) begin
                    n_state = ST_DATA;
                end
            end
            ST_DATA: begin
                if (!i_status.notify || i_status.slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                // no item is taken while reset is held
                o_in_stall = !i_rst_n;
                o_cmd.load = i_in_valid && i_rst_n;
            end
            ST_DIV: begin
                o_cmd.div_step  = !i_status.div_done;
                o_cmd.div_store = i_status.div_done;
            end
            ST_HDR: begin
                o_cmd.hdr_emit = i_status.slot_free;
            end
            ST_DATA: begin
                o_cmd.data_step = !i_status.notify || i_status.slot_free;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: sv/nfrag_dp.sv
`timescale 1ns / 1ps
// framing counters, count divider and output register of the fragmenter
module nfrag_dp #(
    parameter int MAX_MESSAGE_BYTES = nfrag_pkg::MaxMessageBytesDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [nfrag_pkg::MtuW-1:0]  i_cfg_data,
    input  logic [nfrag_pkg::ByteW-1:0] i_data_byte,
    input  logic [nfrag_pkg::LenW-1:0]  i_message_length,
    input  nfrag_pkg::t_cmd             i_cmd,
    output nfrag_pkg::t_status          o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nfrag_pkg::ByteW-1:0] o_out_byte,
    output logic                        o_fragment_last,
    output logic                        o_message_last
);
    import nfrag_pkg::*;

    localparam logic [LenW-1:0] MaxLen = LenW'(MAX_MESSAGE_BYTES);

    // configuration
    logic [MtuW-1:0] r_mtu;
    logic            r_notify;

    // latched item
    logic [ByteW-1:0]  r_data;
    logic [LenW-1:0]   r_len;
    logic [ChunkW-1:0] r_chunk;

    // framing state
    logic [LenW-1:0] r_bytes_seen;
    logic [IdxW-1:0] r_frag_idx;
    logic [IdxW-1:0] r_frag_tot;
    logic [BifW-1:0] r_bif;
    logic            r_split;

    // fragment count divider
    logic [NumW-1:0]    r_div_num;
    logic [ChunkW-1:0]  r_div_rem;
    logic [DivCntW-1:0] r_div_cnt;

    logic [HdrCntW-1:0] r_hdr_cnt;

    logic [ByteW-1:0] r_out_byte;
    logic             r_out_fl;
    logic             r_out_ml;
    logic             r_out_valid;

    logic [LenW-1:0]   len_c;
    logic [MtuW-1:0]   mtu_c;
    logic [ChunkW-1:0] chunk_c;
    logic              split_new;
    logic              first;
    logic [NumW-1:0]   num_init;
    logic [ChunkW:0]   rem_sh;
    logic              q_bit;
    logic [ChunkW:0]   rem_sub;
    logic              msg_last;
    logic              bif_full;
    logic              frag_last;
    logic              slot_free;
    logic [ByteW-1:0]  hdr_byte;

    always_comb begin
        priority if (i_message_length == '0) begin
            len_c = LenW'(1);
        end else if (i_message_length > MaxLen) begin
            len_c = MaxLen;
        end else begin
            len_c = i_message_length;
        end
        priority if (r_mtu < MtuW'(MtuMin)) begin
            mtu_c = MtuW'(MtuMin);
        end else if (r_mtu > MtuW'(MtuMax)) begin
            mtu_c = MtuW'(MtuMax);
        end else begin
            mtu_c = r_mtu;
        end
    end

    assign chunk_c   = ChunkW'(mtu_c - MtuW'(SplitOverhead));
    assign split_new = len_c > LenW'(mtu_c - MtuW'(PassOverhead));
    assign first     = (r_bytes_seen == '0);
    assign num_init  = NumW'(len_c) + NumW'(chunk_c) - NumW'(1);

    // one quotient bit per cycle
    assign rem_sh  = {r_div_rem, r_div_num[NumW-1]};
    assign q_bit   = rem_sh >= {1'b0, r_chunk};
    assign rem_sub = rem_sh - {1'b0, r_chunk};

    assign msg_last  = (NumW'(r_bytes_seen) + NumW'(1)) >= NumW'(r_len);
    assign bif_full  = ({1'b0, r_bif} + (BifW + 1)'(1)) >= (BifW + 1)'(r_chunk);
    assign frag_last = r_split ? (msg_last || bif_full) : msg_last;
    assign slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        unique case (r_hdr_cnt)
            HdrHash0: hdr_byte = HashByte;
            HdrHash1: hdr_byte = HashByte;
            HdrTotal: hdr_byte = r_frag_tot;
            HdrIndex: hdr_byte = r_frag_idx;
            default:  hdr_byte = HashByte;
        endcase
    end

    always_comb begin
        o_status.first_split = first && split_new;
        o_status.hdr_needed  = first ? split_new : (r_split && (r_bif == '0));
        o_status.div_done    = (r_div_cnt == DivCntW'(DivSteps));
        o_status.hdr_last    = (r_hdr_cnt == HdrIndex);
        o_status.slot_free   = slot_free;
        o_status.notify      = r_notify;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu    <= MtuW'(MtuReset);
            r_notify <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgMtu:    r_mtu    <= i_cfg_data;
                CfgNotify: r_notify <= i_cfg_data[0];
                default:   r_mtu    <= r_mtu;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_data  <= i_data_byte;
            r_len   <= len_c;
            r_chunk <= chunk_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_seen <= '0;
            r_frag_idx   <= '0;
            r_frag_tot   <= '0;
            r_bif        <= '0;
            r_split      <= 1'b0;
            r_div_cnt    <= DivCntW'(DivSteps);
            r_hdr_cnt    <= '0;
        end else begin
            if (i_cmd.load) begin
                r_hdr_cnt <= '0;
                if (first) begin
                    r_split    <= split_new;
                    r_bif      <= '0;
                    r_frag_idx <= split_new ? IdxW'(1) : '0;
                    r_frag_tot <= '0;
                    r_div_cnt  <= '0;
                end
            end
            if (i_cmd.div_step) begin
                r_div_cnt <= r_div_cnt + DivCntW'(1);
            end
            if (i_cmd.div_store) begin
                r_frag_tot <= r_div_num[IdxW-1:0];
            end
            if (i_cmd.hdr_emit) begin
                r_hdr_cnt <= r_hdr_cnt + HdrCntW'(1);
            end
            if (i_cmd.data_step) begin
                if (msg_last) begin
                    r_bytes_seen <= '0;
                    r_frag_idx   <= '0;
                    r_frag_tot   <= '0;
                    r_bif        <= '0;
                    r_split      <= 1'b0;
                end else begin
                    r_bytes_seen <= r_bytes_seen + LenW'(1);
                    if (r_split) begin
                        if (frag_last) begin
                            r_bif      <= '0;
                            r_frag_idx <= r_frag_idx + IdxW'(1);
                        end else begin
                            r_bif <= r_bif + BifW'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && first) begin
            r_div_num <= num_init;
            r_div_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[NumW-2:0], q_bit};
            r_div_rem <= q_bit ? rem_sub[ChunkW-1:0] : rem_sh[ChunkW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.hdr_emit || (i_cmd.data_step && r_notify)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.hdr_emit) begin
            r_out_byte <= hdr_byte;
            r_out_fl   <= 1'b0;
            r_out_ml   <= 1'b0;
        end else if (i_cmd.data_step && r_notify) begin
            r_out_byte <= r_data;
            r_out_fl   <= frag_last;
            r_out_ml   <= msg_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_fragment_last = r_out_fl;
    assign o_message_last  = r_out_ml;

    // pass-through messages never touch the fragment counters
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_split |-> (r_bif == '0) && (r_frag_idx == '0))
        else $error("fragment counters moved outside split mode");

    // partial remainder stays below the divisor while dividing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_div_cnt != DivCntW'(DivSteps)) |-> (r_div_rem < r_chunk))
        else $error("divider remainder out of range");

    // headers only belong to split messages
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hdr_emit |-> r_split)
        else $error("header emitted for a pass-through message");

    // a message always ends on a notification boundary
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ml) |-> r_out_fl)
        else $error("message end without fragment end");

endmodule

// File: sv/notify_payload_fragmenter.sv
`timescale 1ns / 1ps
// top level of the notification payload fragmenter
//
// Splits a byte stream into notification payloads for the configured MTU (clamped to
// 23..517). A message of at most MTU-3 bytes goes out unchanged as one notification;
// a longer one is cut into ceil(len/(MTU-7)) fragments, each led by '#', '#', the
// fragment count and the fragment number. One item is handled at a time: a plain data
// byte is accepted, then emitted; each fragment start adds the header, and the first
// byte of a split message adds the bit-serial count division. A stalled output holds
// the item longer. With notify disabled the framing still advances but nothing is
// emitted. Configuration must be written only while idle, which is not enforced.
module notify_payload_fragmenter #(
    parameter int MAX_MESSAGE_BYTES = nfrag_pkg::MaxMessageBytesDef
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [nfrag_pkg::MtuW-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [nfrag_pkg::ByteW-1:0] i_data_byte,
    input  logic [nfrag_pkg::LenW-1:0]  i_message_length,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [nfrag_pkg::ByteW-1:0] o_out_byte,
    output logic                        o_fragment_last,
    output logic                        o_message_last
);
    import nfrag_pkg::*;

    t_cmd    cmd;
    t_status status;

    nfrag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    nfrag_dp #(
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_data_byte      (i_data_byte),
        .i_message_length (i_message_length),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_out_byte       (o_out_byte),
        .o_fragment_last  (o_fragment_last),
        .o_message_last   (o_message_last)
    );

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the notification payload fragmenter
module tb;
    import nfrag_pkg::*;

    localparam int CycleLimit   = 1_000_000;
    localparam int SettleCycles = 40;
    localparam int PhaseItems   = 56;
    localparam int NumPhases    = 8;

    typedef struct packed {
        logic [ByteW-1:0] payload;
        logic             frag_end;
        logic             msg_end;
    } t_out_byte;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic             cfg_index = CfgMtu;
    logic [MtuW-1:0]  cfg_data  = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    logic [ByteW-1:0] data_byte = '0;
    logic [LenW-1:0]  msg_len   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [ByteW-1:0] out_byte;
    logic             frag_last;
    logic             msg_last;

    // predictor copy of the registers and the framing state
    logic [MtuW-1:0]  mtu_reg    = MtuW'(MtuReset);
    logic             notify_reg = 1'b0;
    logic [LenW-1:0]  msg_count  = '0;
    logic [IdxW-1:0]  frag_num   = '0;
    logic [IdxW-1:0]  frag_count = '0;
    logic [BifW-1:0]  frag_fill  = '0;
    logic             splitting  = 1'b0;

    t_out_byte due_bytes[$];

    int  errors        = 0;
    int  items_sent    = 0;
    int  bytes_checked = 0;
    int  split_msgs    = 0;
    int  headers_due   = 0;
    int  cycles        = 0;
    int  stall_left    = 0;
    bit  no_gaps       = 1'b0;
    bit  no_stall      = 1'b0;

    notify_payload_fragmenter dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_message_length (msg_len),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_byte       (out_byte),
        .o_fragment_last  (frag_last),
        .o_message_last   (msg_last)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles >= CycleLimit) begin
            $display("notify_payload_fragmenter regression: fail");
            $finish;
        end
    end

    // frames one message byte and queues the payload bytes it should produce
    function automatic void predict_payload(input logic [ByteW-1:0] d,
                                            input logic [LenW-1:0] len_in);
        int unsigned mtu, chunk, mlen, total;
        logic        at_msg_end, at_frag_end;
        t_out_byte   res[$];
        mtu = mtu_reg;
        if (mtu < MtuMin) mtu = MtuMin;
        if (mtu > MtuMax) mtu = MtuMax;
        mlen = len_in;
        if (mlen < 1) mlen = 1;
        if (mlen > MaxMessageBytesDef) mlen = MaxMessageBytesDef;
        chunk = mtu - SplitOverhead;

        // split decision and fragment count are fixed by the first byte
        if (msg_count == 0) begin
            splitting = (mlen > mtu - PassOverhead);
            frag_fill = '0;
            total = (mlen + chunk - 1) / chunk;
            frag_count = splitting ? total[IdxW-1:0] : '0;
            frag_num = splitting ? IdxW'(1) : '0;
            if (splitting) split_msgs++;
        end

        at_msg_end = (msg_count + 1 >= mlen);

        if (splitting) begin
            if (frag_fill == 0) begin
                res.push_back({HashByte, 1'b0, 1'b0});
                res.push_back({HashByte, 1'b0, 1'b0});
                res.push_back({frag_count, 1'b0, 1'b0});
                res.push_back({frag_num, 1'b0, 1'b0});
                if (notify_reg) headers_due++;
            end
            at_frag_end = at_msg_end || (frag_fill + 1 >= chunk);
            res.push_back({d, at_frag_end, at_msg_end});
            if (at_frag_end) begin
                frag_fill = '0;
                frag_num = frag_num + 1'b1;
            end else begin
                frag_fill = frag_fill + 1'b1;
            end
        end else begin
            res.push_back({d, at_msg_end, at_msg_end});
        end

        msg_count = msg_count + 1'b1;
        if (at_msg_end) begin
            msg_count = '0;
            frag_num = '0;
            frag_count = '0;
            frag_fill = '0;
            splitting = 1'b0;
        end

        // framing advances even with notify off, only the output is dropped
        if (notify_reg) begin
            foreach (res[i]) due_bytes.push_back(res[i]);
        end
    endfunction

    // result checker and output stall pattern
    always @(posedge clk) begin : check_out
        t_out_byte got, want;
        int r;
        if (out_valid && !out_stall) begin
            got = {out_byte, frag_last, msg_last};
            if (due_bytes.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected payload byte %h fl=%b ml=%b", out_byte, frag_last,
                             msg_last);
            end else begin
                want = due_bytes.pop_front();
                bytes_checked++;
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch at byte %0d: expected %h fl=%b ml=%b, got %h fl=%b ml=%b",
                                 bytes_checked, want.payload, want.frag_end, want.msg_end,
                                 got.payload, got.frag_end, got.msg_end);
                end
            end
        end

        if (stall_left > 0) begin
            stall_left--;
        end else begin
            r = $urandom_range(0, 99);
            if (no_stall || r < 50) begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(1, 20);
            end else if (r < 90) begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(8, 40);
            end
        end
    end

    // sends one item; valid stays high when the next item follows with no gap
    task automatic push_byte(input logic [ByteW-1:0] d, input logic [LenW-1:0] len);
        int gap, r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        msg_len   <= len;
        do @(posedge clk); while (in_stall);
        predict_payload(d, len);
        items_sent++;
    endtask

    // waits until every queued byte has come out and the block has gone quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [MtuW-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CfgMtu) mtu_reg = val;
        else notify_reg = val[0];
    endtask

    task automatic test_notify_off();
        push_byte(8'h00, 12'd0);
        // split message begun while dropped, finished once enabled
        push_byte(8'hA5, 12'd30);
        settle();
        write_reg(CfgNotify, 10'h3FF);
        push_byte(8'h5A, 12'd2);
    endtask

    task automatic test_pass_through();
        push_byte(8'hFF, 12'd1);
        push_byte(8'h00, 12'd3);
        push_byte(8'h80, 12'd3);
        push_byte(8'h7F, 12'd3);
        // largest pass-through length at the reset mtu, cut short by the second length
        push_byte(8'h01, 12'd20);
        push_byte(8'hFE, 12'd2);
    endtask

    task automatic test_split_edge();
        push_byte(8'h55, 12'd21);
        push_byte(8'hAA, 12'd2);
    endtask

    task automatic test_length_clamp();
        push_byte(8'hC3, 12'hFFF);
        push_byte(8'h3C, 12'd2);
        push_byte(8'h0F, 12'd2048);
        push_byte(8'hF0, 12'd2);
    endtask

    task automatic test_mtu_clamp();
        settle();
        write_reg(CfgMtu, 10'd0);
        push_byte(8'h12, 12'd21);
        push_byte(8'h34, 12'd2);
        settle();
        write_reg(CfgMtu, 10'h3FF);
        push_byte(8'h56, 12'd514);
        push_byte(8'h78, 12'd2);
        push_byte(8'h9A, 12'd515);
        push_byte(8'hBC, 12'd2);
    endtask

    // messages with random content, some with odd lengths, across mtu and notify settings
    task automatic test_random_phases();
        int unsigned     first_len, body_len, m, r, u;
        logic [MtuW-1:0] v;
        logic [LenW-1:0] len;
        first_len = 1;
        body_len  = 1;
        for (int p = 0; p < NumPhases; p++) begin
            settle();
            case (p)
                0: u = MtuReset;
                1: u = $urandom_range(24, 40);
                2: u = $urandom_range(0, MtuMin - 1);
                3: u = $urandom_range(30, 60);
                4: u = $urandom_range(MtuMax + 1, 1023);
                5: u = MtuMax;
                6: u = $urandom_range(0, 1023);
                default: u = $urandom_range(MtuMin, 35);
            endcase
            v = u[MtuW-1:0];
            write_reg(CfgMtu, v);
            u = $urandom_range(0, 1023);
            v = u[MtuW-1:0];
            v[0] = (p != 6);
            write_reg(CfgNotify, v);
            no_gaps  = (p == 3);
            no_stall = (p == 1);

            for (int k = 0; k < PhaseItems; k++) begin
                if (msg_count == 0) begin
                    m = mtu_reg;
                    if (m < MtuMin) m = MtuMin;
                    if (m > MtuMax) m = MtuMax;
                    r = $urandom_range(0, 99);
                    if (r < 10) begin
                        // long or zero declared length, then shortened on later bytes
                        first_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(600, 4095);
                        body_len = $urandom_range(1, 12);
                    end else begin
                        if (r < 30 && m <= 64)
                            body_len = m - 4 + $urandom_range(0, 2);
                        else
                            body_len = $urandom_range(1, (m <= 40) ? 2 * (m - 7) + 4 : 40);
                        first_len = body_len;
                    end
                end
                len = (msg_count == 0) ? first_len[LenW-1:0] : body_len[LenW-1:0];
                if ($urandom_range(0, 24) == 0) begin
                    u = $urandom_range(0, 4095);
                    len = u[LenW-1:0];
                end
                u = $urandom_range(0, 255);
                push_byte(u[ByteW-1:0], len);
            end
        end
        no_gaps  = 1'b0;
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_notify_off();
        test_pass_through();
        test_split_edge();
        test_length_clamp();
        test_mtu_clamp();
        test_random_phases();
        settle();

        $display("sent %0d items, checked %0d payload bytes, %0d split messages, %0d headers",
                 items_sent, bytes_checked, split_msgs, headers_due);
        $display("mtu swept below and above its range, notify toggled, %0d mismatches",
                 errors);
        if (errors == 0) begin
            $display("notify_payload_fragmenter regression: pass");
        end else begin
            $display("notify_payload_fragmenter regression: fail");
        end
        $finish;
    end

endmodule

// File: notify_payload_fragmenter.f
sv/nfrag_pkg.sv
sv/nfrag_ctrl.sv
sv/nfrag_dp.sv
sv/notify_payload_fragmenter.sv
test/tb.sv
